>>> rtl/pktfifo_pkg.sv
// types, codes and control structs shared by the packet fifo modules
package pktfifo_pkg;

    localparam logic [1:0] CMD_BEGIN_ENQ = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_BEGIN_DEQ = 2'd2;
    localparam logic [1:0] CMD_READ      = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_SEQ       = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] packet_length;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_length;
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic       write_open;
        logic       read_open;
        logic       no_room;
        logic       no_packet;
    } t_dp_status;

    typedef struct packed {
        logic       req_load;
        logic       do_enq;
        logic       do_write;
        logic       do_deq;
        logic       do_read;
        logic       res_load;
        logic [1:0] res_status;
        logic       fetch_load;
    } t_ctrl_cmd;

endpackage

>>> rtl/pktfifo_ram.sv
// generic single write port ram with registered read
module pktfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/pktfifo_ctrl.sv
// request sequencer for the packet fifo
module pktfifo_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    input  pktfifo_pkg::t_dp_status i_status,
    output pktfifo_pkg::t_ctrl_cmd  o_cmd
);
    import pktfifo_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   go_fetch;

    always_comb begin
        case (i_status.cmd)
            CMD_BEGIN_DEQ: go_fetch = !i_status.read_open && !i_status.no_packet;
            CMD_READ:      go_fetch = i_status.read_open;
            default:       go_fetch = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = go_fetch ? S_FETCH : S_RESULT;
            end
            S_FETCH: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.req_load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.res_load = 1'b1;
                case (i_status.cmd)
                    CMD_BEGIN_ENQ: begin
                        if (i_status.write_open) begin
                            o_cmd.res_status = STS_SEQ;
                        end else if (i_status.no_room) begin
                            o_cmd.res_status = STS_FULL;
                        end else begin
                            o_cmd.do_enq = 1'b1;
                        end
                    end
                    CMD_WRITE: begin
                        if (!i_status.write_open) begin
                            o_cmd.res_status = STS_SEQ;
                        end else begin
                            o_cmd.do_write = 1'b1;
                        end
                    end
                    CMD_BEGIN_DEQ: begin
                        if (i_status.read_open) begin
                            o_cmd.res_status = STS_SEQ;
                        end else if (i_status.no_packet) begin
                            o_cmd.res_status = STS_FULL;
                        end else begin
                            o_cmd.do_deq = 1'b1;
                        end
                    end
                    default: begin
                        if (!i_status.read_open) begin
                            o_cmd.res_status = STS_SEQ;
                        end else begin
                            o_cmd.do_read = 1'b1;
                        end
                    end
                endcase
            end
            S_FETCH: begin
                o_cmd.fetch_load = 1'b1;
            end
            S_RESULT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/pktfifo_dp.sv
// pointers, counters, stores and result register of the packet fifo
module pktfifo_dp #(
    parameter int DATA_DEPTH   = 2048,
    parameter int PACKET_DEPTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pktfifo_pkg::t_in_item   i_in_data,
    input  pktfifo_pkg::t_ctrl_cmd  i_cmd,
    output pktfifo_pkg::t_dp_status o_status,
    output pktfifo_pkg::t_out_item  o_out_data
);
    import pktfifo_pkg::*;

    localparam int BW = $clog2(DATA_DEPTH);
    localparam int LW = $clog2(PACKET_DEPTH);
    localparam int SW = ((BW > 8) ? BW : 8) + 1;
    localparam logic [BW-1:0] BYTE_LAST = BW'(DATA_DEPTH - 1);
    localparam logic [LW-1:0] LEN_LAST  = LW'(PACKET_DEPTH - 1);
    localparam logic [SW-1:0] BYTE_CAP  = SW'(DATA_DEPTH);

    t_in_item  r_req;
    t_out_item r_out;
    logic [BW-1:0] r_byte_wr_ptr;
    logic [BW-1:0] r_byte_rd_ptr;
    logic [BW-1:0] r_bytes_used;
    logic [LW-1:0] r_len_wr_ptr;
    logic [LW-1:0] r_len_rd_ptr;
    logic [LW-1:0] r_packets_held;
    logic [7:0]    r_write_left;
    logic [7:0]    r_read_left;

    logic [SW-1:0] room_sum;
    logic          publish;
    logic [7:0]    len_rd_data;
    logic [7:0]    byte_rd_data;

    assign room_sum = SW'(r_bytes_used) + SW'(r_req.packet_length);

    assign o_status.cmd        = r_req.cmd;
    assign o_status.write_open = (r_write_left != 8'd0);
    assign o_status.read_open  = (r_read_left != 8'd0);
    assign o_status.no_room    = (room_sum >= BYTE_CAP) || (r_packets_held >= LEN_LAST);
    assign o_status.no_packet  = (r_packets_held == '0);

    assign publish = (i_cmd.do_enq && (r_req.packet_length == 8'd0))
                  || (i_cmd.do_write && (r_write_left == 8'd1));

    pktfifo_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_DEPTH)
    ) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.do_enq),
        .i_wr_addr (r_len_wr_ptr),
        .i_wr_data (r_req.packet_length),
        .i_rd_en   (i_cmd.do_deq),
        .i_rd_addr (r_len_rd_ptr),
        .o_rd_data (len_rd_data)
    );

    pktfifo_ram #(
        .WIDTH (8),
        .DEPTH (DATA_DEPTH)
    ) u_byte_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.do_write),
        .i_wr_addr (r_byte_wr_ptr),
        .i_wr_data (r_req.data_byte),
        .i_rd_en   (i_cmd.do_read),
        .i_rd_addr (r_byte_rd_ptr),
        .o_rd_data (byte_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_in_data;
        end
        if (i_cmd.res_load) begin
            r_out.status     <= i_cmd.res_status;
            r_out.out_length <= 8'd0;
            r_out.out_byte   <= 8'd0;
            r_out.last_byte  <= i_cmd.do_read && (r_read_left == 8'd1);
        end else if (i_cmd.fetch_load) begin
            if (r_req.cmd == CMD_BEGIN_DEQ) begin
                r_out.out_length <= len_rd_data;
            end else begin
                r_out.out_byte <= byte_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_wr_ptr  <= '0;
            r_byte_rd_ptr  <= '0;
            r_bytes_used   <= '0;
            r_len_wr_ptr   <= '0;
            r_len_rd_ptr   <= '0;
            r_packets_held <= '0;
            r_write_left   <= 8'd0;
            r_read_left    <= 8'd0;
        end else begin
            if (i_cmd.do_enq) begin
                r_bytes_used <= room_sum[BW-1:0];
                r_write_left <= r_req.packet_length;
            end
            if (i_cmd.do_write) begin
                r_byte_wr_ptr <= (r_byte_wr_ptr == BYTE_LAST) ? '0 : r_byte_wr_ptr + 1'b1;
                r_write_left  <= r_write_left - 8'd1;
            end
            if (publish) begin
                r_len_wr_ptr <= (r_len_wr_ptr == LEN_LAST) ? '0 : r_len_wr_ptr + 1'b1;
            end
            if (i_cmd.do_deq) begin
                r_len_rd_ptr <= (r_len_rd_ptr == LEN_LAST) ? '0 : r_len_rd_ptr + 1'b1;
            end
            if (publish && !i_cmd.do_deq) begin
                r_packets_held <= r_packets_held + 1'b1;
            end else if (i_cmd.do_deq && !publish) begin
                r_packets_held <= r_packets_held - 1'b1;
            end
            if (i_cmd.do_read) begin
                r_byte_rd_ptr <= (r_byte_rd_ptr == BYTE_LAST) ? '0 : r_byte_rd_ptr + 1'b1;
                r_read_left   <= r_read_left - 8'd1;
                if (r_bytes_used != '0) begin
                    r_bytes_used <= r_bytes_used - 1'b1;
                end
            end
            if (i_cmd.fetch_load && (r_req.cmd == CMD_BEGIN_DEQ)) begin
                r_read_left <= len_rd_data;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/packet_fifo_with_length_queue.sv
// top level of the whole-packet fifo with a separate length queue
//
// one request enters on i_in_valid / o_in_stall and carries a command with a
// packet length or a data byte. every request gives exactly one response on
// o_out_valid / i_out_stall with a status, a popped length, a read byte and a
// last-byte flag.
// requests are handled one at a time. a begin_enqueue or write_byte request,
// or any request that ends in an error status, goes from the execute state
// straight to the result state; a begin_dequeue or read_byte that succeeds
// passes through a fetch state first, for the registered read of the length
// or byte memory. the next request is taken in the cycle after its response
// is taken.
// while the receiver stalls, the response holds and o_in_stall stays high.
// reset (synchronous, active low) empties both queues and closes any open
// packet; the memories themselves are not cleared.
module packet_fifo_with_length_queue #(
    parameter int DATA_DEPTH   = 2048,
    parameter int PACKET_DEPTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  pktfifo_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output pktfifo_pkg::t_out_item o_out_data
);
    import pktfifo_pkg::*;

    t_dp_status dp_status;
    t_ctrl_cmd  ctrl_cmd;

    pktfifo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (ctrl_cmd)
    );

    pktfifo_dp #(
        .DATA_DEPTH   (DATA_DEPTH),
        .PACKET_DEPTH (PACKET_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (ctrl_cmd),
        .o_status   (dp_status),
        .o_out_data (o_out_data)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the whole-packet fifo with its length queue
module tb_top;
    import pktfifo_pkg::*;

    localparam int DATA_DEPTH    = 2048;
    localparam int PACKET_DEPTH  = 32;
    localparam int MIXED_ITEMS   = 600;
    localparam int EDGE_ITEMS    = 100;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_CYCLES    = 500000;
    localparam int NUM_ROWS      = 25;

    typedef enum {STAGE_FILL, STAGE_DRAIN, STAGE_BIG, STAGE_EDGE} t_stage;

    typedef struct packed {
        t_in_item  req;
        logic      fixed_resp;
        t_out_item resp;
    } t_row;

    localparam t_out_item RESP_OK   = '{STS_OK,   8'd0, 8'd0, 1'b0};
    localparam t_out_item RESP_FULL = '{STS_FULL, 8'd0, 8'd0, 1'b0};
    localparam t_out_item RESP_SEQ  = '{STS_SEQ,  8'd0, 8'd0, 1'b0};

    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{'{CMD_READ,      8'd0,   8'h00}, 1'b1, RESP_SEQ},
        '{'{CMD_BEGIN_DEQ, 8'd0,   8'h00}, 1'b1, RESP_FULL},
        '{'{CMD_WRITE,     8'hff,  8'hff}, 1'b1, RESP_SEQ},
        '{'{CMD_BEGIN_ENQ, 8'd0,   8'h00}, 1'b1, RESP_OK},
        '{'{CMD_BEGIN_DEQ, 8'd0,   8'h00}, 1'b1, RESP_OK},
        '{'{CMD_READ,      8'd0,   8'h00}, 1'b1, RESP_SEQ},
        '{'{CMD_BEGIN_ENQ, 8'd3,   8'h00}, 1'b1, RESP_OK},
        '{'{CMD_BEGIN_ENQ, 8'd255, 8'h00}, 1'b1, RESP_SEQ},
        '{'{CMD_WRITE,     8'd0,   8'h00}, 1'b1, RESP_OK},
        '{'{CMD_BEGIN_DEQ, 8'd0,   8'h00}, 1'b1, RESP_FULL},
        '{'{CMD_WRITE,     8'd0,   8'hff}, 1'b1, RESP_OK},
        '{'{CMD_WRITE,     8'hff,  8'ha5}, 1'b1, RESP_OK},
        '{'{CMD_BEGIN_ENQ, 8'd2,   8'h00}, 1'b1, RESP_OK},
        '{'{CMD_BEGIN_DEQ, 8'd0,   8'h00}, 1'b0, '0},
        '{'{CMD_BEGIN_DEQ, 8'd0,   8'h00}, 1'b1, RESP_SEQ},
        '{'{CMD_READ,      8'd0,   8'h00}, 1'b0, '0},
        '{'{CMD_WRITE,     8'd0,   8'h5a}, 1'b1, RESP_OK},
        '{'{CMD_READ,      8'd0,   8'h00}, 1'b0, '0},
        '{'{CMD_WRITE,     8'd0,   8'h81}, 1'b1, RESP_OK},
        '{'{CMD_READ,      8'd0,   8'h00}, 1'b0, '0},
        '{'{CMD_READ,      8'd0,   8'h00}, 1'b1, RESP_SEQ},
        '{'{CMD_BEGIN_DEQ, 8'd0,   8'h00}, 1'b0, '0},
        '{'{CMD_READ,      8'd0,   8'h00}, 1'b0, '0},
        '{'{CMD_READ,      8'd0,   8'h00}, 1'b0, '0},
        '{'{CMD_BEGIN_ENQ, 8'd255, 8'h00}, 1'b1, RESP_OK}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    logic [7:0]                      byte_ring   [DATA_DEPTH];
    logic [7:0]                      length_ring [PACKET_DEPTH];
    logic [$clog2(DATA_DEPTH)-1:0]   ring_wr_ptr    = '0;
    logic [$clog2(DATA_DEPTH)-1:0]   ring_rd_ptr    = '0;
    logic [$clog2(DATA_DEPTH):0]     ring_fill      = '0;
    logic [$clog2(PACKET_DEPTH)-1:0] len_wr_ptr     = '0;
    logic [$clog2(PACKET_DEPTH)-1:0] len_rd_ptr     = '0;
    logic [$clog2(PACKET_DEPTH):0]   queued_packets = '0;
    logic [7:0]                      bytes_to_write = '0;
    logic [7:0]                      bytes_to_read  = '0;

    t_out_item expected_responses [$];
    int        error_count      = 0;
    int        byte_full_hits   = 0;
    int        packet_full_hits = 0;
    int        cycle_count      = 0;
    bit        idle_on          = 1'b1;
    bit        long_hold        = 1'b0;

    packet_fifo_with_length_queue #(
        .DATA_DEPTH   (DATA_DEPTH),
        .PACKET_DEPTH (PACKET_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic commit_length();
        len_wr_ptr     = len_wr_ptr + 1'b1;
        queued_packets = queued_packets + 1'b1;
    endtask

    task automatic predict_fifo_response(input t_in_item r, output t_out_item o);
        o        = '0;
        o.status = STS_OK;
        case (r.cmd)
            CMD_BEGIN_ENQ: begin
                if (bytes_to_write != 0) begin
                    o.status = STS_SEQ;
                end else if (int'(ring_fill) + int'(r.packet_length) >= DATA_DEPTH) begin
                    o.status = STS_FULL;
                    byte_full_hits++;
                end else if (int'(queued_packets) + 1 >= PACKET_DEPTH) begin
                    o.status = STS_FULL;
                    packet_full_hits++;
                end else begin
                    length_ring[len_wr_ptr] = r.packet_length;
                    ring_fill = ring_fill + r.packet_length;
                    if (r.packet_length == 0) begin
                        commit_length();
                    end else begin
                        bytes_to_write = r.packet_length;
                    end
                end
            end
            CMD_WRITE: begin
                if (bytes_to_write == 0) begin
                    o.status = STS_SEQ;
                end else begin
                    byte_ring[ring_wr_ptr] = r.data_byte;
                    ring_wr_ptr    = ring_wr_ptr + 1'b1;
                    bytes_to_write = bytes_to_write - 1'b1;
                    if (bytes_to_write == 0) begin
                        commit_length();
                    end
                end
            end
            CMD_BEGIN_DEQ: begin
                if (bytes_to_read != 0) begin
                    o.status = STS_SEQ;
                end else if (queued_packets == 0) begin
                    o.status = STS_FULL;
                end else begin
                    o.out_length   = length_ring[len_rd_ptr];
                    len_rd_ptr     = len_rd_ptr + 1'b1;
                    queued_packets = queued_packets - 1'b1;
                    bytes_to_read  = o.out_length;
                end
            end
            default: begin
                if (bytes_to_read == 0) begin
                    o.status = STS_SEQ;
                end else begin
                    o.out_byte    = byte_ring[ring_rd_ptr];
                    ring_rd_ptr   = ring_rd_ptr + 1'b1;
                    bytes_to_read = bytes_to_read - 1'b1;
                    if (ring_fill != 0) begin
                        ring_fill = ring_fill - 1'b1;
                    end
                    o.last_byte = (bytes_to_read == 0);
                end
            end
        endcase
    endtask

    function automatic bit fifo_drained();
        return queued_packets == 0 && bytes_to_read == 0 && bytes_to_write == 0;
    endfunction

    function automatic t_in_item make_request(input t_stage stage);
        t_in_item r;
        int       pick;
        int       pick_len;
        int       room;
        pick            = $urandom_range(0, 99);
        pick_len        = $urandom_range(0, 99);
        room            = DATA_DEPTH - 1 - int'(ring_fill);
        r.data_byte     = 8'($urandom_range(0, 255));
        r.packet_length = 8'($urandom_range(0, 255));
        if (stage == STAGE_BIG || (stage == STAGE_EDGE && room >= 255)) begin
            r.packet_length = 8'($urandom_range(200, 255));
        end else if (stage == STAGE_EDGE) begin
            // land right at or just past the byte capacity
            if (pick_len < 80) begin
                r.packet_length = 8'(room + $urandom_range(0, 1));
            end
        end else if (pick_len < 30) begin
            r.packet_length = 8'd0;
        end else if (pick_len < 85) begin
            r.packet_length = 8'($urandom_range(1, 8));
        end else if (pick_len < 97) begin
            r.packet_length = 8'($urandom_range(9, 60));
        end

        if (pick < 4) begin
            r.cmd = 2'($urandom_range(0, 3));
        end else if (bytes_to_write != 0 &&
                     (pick < 85 || stage == STAGE_BIG || stage == STAGE_EDGE)) begin
            r.cmd = CMD_WRITE;
        end else if (bytes_to_read != 0 && pick < 90 && stage != STAGE_BIG) begin
            r.cmd = CMD_READ;
        end else begin
            case (stage)
                STAGE_FILL:  r.cmd = ($urandom_range(0, 9) != 0) ? CMD_BEGIN_ENQ : CMD_BEGIN_DEQ;
                STAGE_DRAIN: r.cmd = ($urandom_range(0, 9) == 0) ? CMD_BEGIN_ENQ : CMD_BEGIN_DEQ;
                STAGE_BIG:   r.cmd = CMD_BEGIN_ENQ;
                default:     r.cmd = ($urandom_range(0, 9) < 6) ? CMD_BEGIN_ENQ : CMD_BEGIN_DEQ;
            endcase
        end
        return r;
    endfunction

    task automatic send_request(input t_in_item r, input logic fixed_resp,
                                input t_out_item fixed_value);
        t_out_item predicted;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        predict_fifo_response(r, predicted);
        expected_responses.push_back(fixed_resp ? fixed_value : predicted);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_response(input t_out_item got);
        t_out_item want;
        if (expected_responses.size() == 0) begin
            $display("%0t: response with none expected, actual %h", $time, got);
            error_count++;
        end else begin
            want = expected_responses.pop_front();
            compare_field("status",     8'(want.status),    8'(got.status));
            compare_field("out_length", want.out_length,    got.out_length);
            compare_field("out_byte",   want.out_byte,      got.out_byte);
            compare_field("last_byte",  8'(want.last_byte), 8'(got.last_byte));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_response(o_out_data);
        end
    end

    initial begin : receiver
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_stage stage;
        int     full_mark;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_ROWS; k++) begin
            send_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].fixed_resp,
                         DIRECTED_ROWS[k].resp);
        end

        // alternate filling to the packet limit and draining back to empty
        stage     = STAGE_FILL;
        full_mark = packet_full_hits;
        for (int n = 0; n < MIXED_ITEMS; n++) begin
            idle_on = (n / 100) % 3 != 2;
            if (n == 300) begin
                long_hold = 1'b1;
            end
            if (n == 550) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (expected_responses.size() != 0) @(posedge i_clk);
            end
            send_request(make_request(stage), 1'b0, '0);
            if (stage == STAGE_FILL && packet_full_hits != full_mark) begin
                stage = STAGE_DRAIN;
            end else if (stage == STAGE_DRAIN && fifo_drained()) begin
                stage     = STAGE_FILL;
                full_mark = packet_full_hits;
            end
        end

        idle_on = 1'b1;
        while (!fifo_drained()) begin
            send_request(make_request(STAGE_DRAIN), 1'b0, '0);
        end

        // large packets until the byte ring refuses one
        full_mark = byte_full_hits;
        while (byte_full_hits == full_mark) begin
            send_request(make_request(STAGE_BIG), 1'b0, '0);
        end

        idle_on = 1'b0;
        for (int n = 0; n < EDGE_ITEMS; n++) begin
            send_request(make_request(STAGE_EDGE), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
